### hw/rtl/wftl_pkg.sv
// Shared types, constants and status codes for the word frequency table.
package wftl_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int LIST_MAX    = 16;
    localparam int WORD_BYTES  = 8;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int OCC_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W  = $clog2(LIST_MAX + 1);

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Result status codes.
    localparam logic [2:0] ST_COUNTED    = 3'd0;
    localparam logic [2:0] ST_ADDED      = 3'd1;
    localparam logic [2:0] ST_REPLACED   = 3'd2;
    localparam logic [2:0] ST_LIST_ENTRY = 3'd3;
    localparam logic [2:0] ST_LIST_EMPTY = 3'd4;

    // Input action codes.
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_LIST   = 1'b1;

    // Keeps only the low WORD_BYTES bytes of a word.
    function automatic logic [63:0] word_mask_f();
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < WORD_BYTES && b < 8; b++) begin
            m[8*b +: 8] = 8'hFF;
        end
        return m;
    endfunction

    localparam logic [63:0] WORD_MASK = word_mask_f();

    typedef struct packed {
        logic        action;
        logic [63:0] word;
        logic [3:0]  emotion_code;
        logic [31:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [63:0] word_out;
        logic [15:0] count_out;
        logic [6:0]  entries_in_use;
        logic        last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic rec_commit;
        logic list_emit;
        logic emit_empty;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_list;
        logic limit_zero;
        logic scan_done;
        logic list_last;
        logic out_free;
    } sts_t;

endpackage

### hw/rtl/wftl_datapath.sv
// Datapath of the word frequency table: entry memories, scan logic and result register.
module wftl_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  wftl_pkg::in_item_t s_data,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_data,
    input  wftl_pkg::cmd_t     cmd,
    output wftl_pkg::sts_t     sts,
    output logic               m_valid,
    input  logic               m_ready,
    output wftl_pkg::out_item_t m_data
);
    import wftl_pkg::*;

    // Entry memories, one address per cycle.
    logic [63:0] word_mem  [TABLE_DEPTH];
    logic [15:0] count_mem [TABLE_DEPTH];
    logic [31:0] first_mem [TABLE_DEPTH];
    logic [31:0] last_mem  [TABLE_DEPTH];
    logic [3:0]  emo_mem   [TABLE_DEPTH];

    in_item_t         item_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic [4:0]       max_list_reg;
    logic [OCC_W-1:0] scan_reg;
    logic             rd_vld_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [63:0]      rd_word_reg;
    logic [15:0]      rd_count_reg;
    logic             match_found_reg;
    logic [SLOT_W-1:0] match_idx_reg;
    logic [15:0]      match_count_reg;
    logic             best_found_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [15:0]      best_count_reg;
    logic [63:0]      best_word_reg;
    logic [TABLE_DEPTH-1:0] used_reg;
    logic [LIM_W-1:0] limit_reg;
    logic [LIM_W-1:0] limit_next;
    logic [LIM_W-1:0] list_k_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic             issue;
    logic             is_match;
    logic             best_upd;
    logic             full;
    logic [SLOT_W-1:0] wr_idx;
    logic [15:0]      new_count;
    logic [2:0]       rec_status;
    logic [LIM_W-1:0] ml_clamped;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_list_reg <= 5'd10;
        end else if (cfg_we) begin
            max_list_reg <= cfg_data;
        end
    end

    // List length: max_list clamped to 1..LIST_MAX, then to the occupied count.
    always_comb begin
        if (max_list_reg == '0) begin
            ml_clamped = LIM_W'(1);
        end else if (max_list_reg > LIST_MAX) begin
            ml_clamped = LIM_W'(LIST_MAX);
        end else begin
            ml_clamped = LIM_W'(max_list_reg);
        end
        if (occ_reg < OCC_W'(ml_clamped)) begin
            limit_next = LIM_W'(occ_reg);
        end else begin
            limit_next = ml_clamped;
        end
    end

    // Item capture and list bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_k_reg <= '0;
            limit_reg  <= '0;
            used_reg   <= '0;
        end else if (cmd.load) begin
            list_k_reg <= '0;
            limit_reg  <= limit_next;
            used_reg   <= '0;
        end else if (cmd.list_emit) begin
            list_k_reg           <= list_k_reg + 1'b1;
            used_reg[best_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= {s_data.action, s_data.word & WORD_MASK, s_data.emotion_code,
                         s_data.now_seconds};
        end
    end

    // Scan address counter and registered memory read.
    assign issue = cmd.scan_step && (scan_reg < occ_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
            if (cmd.scan_start) begin
                scan_reg <= '0;
            end else if (issue) begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_idx_reg   <= scan_reg[SLOT_W-1:0];
            rd_word_reg  <= word_mem[scan_reg[SLOT_W-1:0]];
            rd_count_reg <= count_mem[scan_reg[SLOT_W-1:0]];
        end
    end

    // Compare the entry read back: word match, and minimum or maximum count.
    assign is_match = rd_vld_reg && (item_reg.action == ACT_RECORD) && !match_found_reg
                      && (rd_word_reg == item_reg.word);

    always_comb begin
        best_upd = 1'b0;
        if (rd_vld_reg) begin
            if (item_reg.action == ACT_RECORD) begin
                best_upd = !best_found_reg || (rd_count_reg < best_count_reg);
            end else begin
                best_upd = !used_reg[rd_idx_reg]
                           && (!best_found_reg || (rd_count_reg > best_count_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
        end else if (cmd.scan_start) begin
            match_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
        end else begin
            if (is_match) begin
                match_found_reg <= 1'b1;
            end
            if (best_upd) begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_match) begin
            match_idx_reg   <= rd_idx_reg;
            match_count_reg <= rd_count_reg;
        end
        if (best_upd) begin
            best_idx_reg   <= rd_idx_reg;
            best_count_reg <= rd_count_reg;
            best_word_reg  <= rd_word_reg;
        end
    end

    // Record update: counted, added to a free slot or replacing the least frequent.
    assign full = (occ_reg >= OCC_W'(TABLE_DEPTH));

    always_comb begin
        if (match_found_reg) begin
            wr_idx     = match_idx_reg;
            rec_status = ST_COUNTED;
            new_count  = (match_count_reg == COUNT_MAX) ? COUNT_MAX : match_count_reg + 16'd1;
            occ_next   = occ_reg;
        end else if (full) begin
            wr_idx     = best_idx_reg;
            rec_status = ST_REPLACED;
            new_count  = 16'd1;
            occ_next   = occ_reg;
        end else begin
            wr_idx     = occ_reg[SLOT_W-1:0];
            rec_status = ST_ADDED;
            new_count  = 16'd1;
            occ_next   = occ_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (cmd.rec_commit) begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rec_commit) begin
            count_mem[wr_idx] <= new_count;
            last_mem[wr_idx]  <= item_reg.now_seconds;
            if (!match_found_reg) begin
                word_mem[wr_idx]  <= item_reg.word;
                first_mem[wr_idx] <= item_reg.now_seconds;
                emo_mem[wr_idx]   <= item_reg.emotion_code;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.rec_commit || cmd.list_emit || cmd.emit_empty) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rec_commit) begin
            m_data_reg.status         <= rec_status;
            m_data_reg.slot           <= 6'(wr_idx);
            m_data_reg.word_out       <= item_reg.word;
            m_data_reg.count_out      <= new_count;
            m_data_reg.entries_in_use <= 7'(occ_next);
            m_data_reg.last           <= 1'b1;
        end else if (cmd.list_emit) begin
            m_data_reg.status         <= ST_LIST_ENTRY;
            m_data_reg.slot           <= 6'(best_idx_reg);
            m_data_reg.word_out       <= best_word_reg;
            m_data_reg.count_out      <= best_count_reg;
            m_data_reg.entries_in_use <= 7'(occ_reg);
            m_data_reg.last           <= sts.list_last;
        end else if (cmd.emit_empty) begin
            m_data_reg.status         <= ST_LIST_EMPTY;
            m_data_reg.slot           <= '0;
            m_data_reg.word_out       <= '0;
            m_data_reg.count_out      <= '0;
            m_data_reg.entries_in_use <= 7'(occ_reg);
            m_data_reg.last           <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Status back to the controller.
    always_comb begin
        sts.is_list    = (item_reg.action == ACT_LIST);
        sts.limit_zero = (limit_reg == '0);
        sts.scan_done  = (scan_reg >= occ_reg) && !rd_vld_reg;
        sts.list_last  = (LIM_W'(list_k_reg + 1'b1) == limit_reg);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // A new word in a table that is not full takes exactly one more slot.
    a_occ_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rec_commit && !match_found_reg && !full)
            |=> (occ_reg == $past(occ_reg) + 1'b1))
        else $error("occupied count did not grow on an added word");

    // Each list result marks exactly one further entry as reported.
    a_used_one: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.list_emit |=> ($countones(used_reg) == $countones($past(used_reg)) + 1))
        else $error("list result did not mark one new entry");

    // The number of reported entries never passes the list length.
    a_k_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.list_emit |-> (list_k_reg < limit_reg))
        else $error("list result beyond the list length");

endmodule

### hw/rtl/wftl_ctrl.sv
// Controller state machine of the word frequency table.
module wftl_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  wftl_pkg::sts_t sts,
    output wftl_pkg::cmd_t cmd
);
    import wftl_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_LEMIT  = 3'd4;
    localparam logic [2:0] S_EMPTY  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands to the datapath.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.scan_start = 1'b1;
                if (sts.is_list && sts.limit_zero) begin
                    state_next = S_EMPTY;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = sts.is_list ? S_LEMIT : S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    cmd.rec_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LEMIT: begin
                if (sts.out_free) begin
                    cmd.list_emit = 1'b1;
                    state_next    = sts.list_last ? S_IDLE : S_PREP;
                end
            end
            S_EMPTY: begin
                if (sts.out_free) begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/word_frequency_table_lfu_top.sv
// Top level of the word frequency table with least-frequent replacement.
//
// Input channel s_valid/s_ready/s_data: a record item counts a word or adds
// it to the table (replacing the lowest count when all slots are full); a
// list item asks for the most frequent entries in descending count order.
// Result channel m_valid/m_ready/m_data: one result per record item; per list
// item, one to max_list (clamped to 1..LIST_MAX) but at most occupied results,
// the final one flagged by last; an empty table answers a list with a single
// list-empty result. Configuration channel cfg_valid/cfg_ready/cfg_data writes
// max_list (reset value 10); it is always ready; the user must write it only
// while the block is idle, which the block itself does not enforce. A record
// item makes one pass over the table; a list item, one per result. Each
// pass reads the table memories through their single read port, one entry
// per cycle. One item is worked on at a time.
// A result waits in the output register while m_ready is low; the next item
// may be accepted meanwhile, and its result waits until the register is free.
// Synchronous reset (aresetn low) empties the table and restores max_list.
module word_frequency_table_lfu_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wftl_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wftl_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_data
);
    import wftl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The configuration register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    wftl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wftl_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### sim/word_frequency_table_lfu_top_tb.sv
// Self-checking testbench for the word frequency table with least-frequent replacement.
`timescale 1ns / 1ps

module word_frequency_table_lfu_top_tb;
    import wftl_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int POOL_SIZE      = 96;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;

    // Shadow copy of the table and the list length register.
    logic [63:0] tbl_word       [TABLE_DEPTH];
    logic [15:0] tbl_count      [TABLE_DEPTH];
    logic [31:0] tbl_first_seen [TABLE_DEPTH];
    logic [31:0] tbl_last_seen  [TABLE_DEPTH];
    logic [3:0]  tbl_emotion    [TABLE_DEPTH];
    int          n_used;
    logic [4:0]  max_list_reg;

    out_item_t   pending_results [$];
    out_item_t   oldest_result;
    logic [63:0] word_pool [POOL_SIZE];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int items_sent;
    int results_seen;
    int list_items;
    int cfg_writes;
    int quiet_cycles;

    word_frequency_table_lfu_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Works out the results of one accepted item and updates the shadow table.
    function automatic void predict_item(in_item_t it);
        logic [63:0] w;
        logic [63:0] taken;
        int          i;
        int          k;
        int          hit;
        int          pick;
        int          lim;
        out_item_t   r;
        w = it.word & WORD_MASK;
        r = '0;
        if (it.action == ACT_RECORD) begin
            hit = -1;
            for (i = 0; i < n_used && hit < 0; i++) begin
                if (tbl_word[i] == w) hit = i;
            end
            if (hit >= 0) begin
                if (tbl_count[hit] != COUNT_MAX) tbl_count[hit] = tbl_count[hit] + 16'd1;
                tbl_last_seen[hit] = it.now_seconds;
                r.status    = ST_COUNTED;
                r.slot      = hit[5:0];
                r.count_out = tbl_count[hit];
            end else begin
                // A free slot if there is one, else the lowest count at the lowest index.
                if (n_used < TABLE_DEPTH) begin
                    pick = n_used;
                    n_used++;
                    r.status = ST_ADDED;
                end else begin
                    pick = 0;
                    for (i = 1; i < TABLE_DEPTH; i++) begin
                        if (tbl_count[i] < tbl_count[pick]) pick = i;
                    end
                    r.status = ST_REPLACED;
                end
                tbl_word[pick]       = w;
                tbl_count[pick]      = 16'd1;
                tbl_first_seen[pick] = it.now_seconds;
                tbl_last_seen[pick]  = it.now_seconds;
                tbl_emotion[pick]    = it.emotion_code;
                r.slot      = pick[5:0];
                r.count_out = 16'd1;
            end
            r.word_out       = w;
            r.entries_in_use = 7'(n_used);
            r.last           = 1'b1;
            pending_results.push_back(r);
        end else begin
            lim = (max_list_reg == 5'd0) ? 1 : int'(max_list_reg);
            if (lim > LIST_MAX) lim = LIST_MAX;
            if (lim > n_used) lim = n_used;
            if (lim == 0) begin
                r.status = ST_LIST_EMPTY;
                r.last   = 1'b1;
                pending_results.push_back(r);
            end else begin
                // Repeated selection of the highest remaining count, lower index first.
                taken = '0;
                for (k = 0; k < lim; k++) begin
                    pick = -1;
                    for (i = 0; i < n_used; i++) begin
                        if (!taken[i] && (pick < 0 || tbl_count[i] > tbl_count[pick])) pick = i;
                    end
                    taken[pick]      = 1'b1;
                    r.status         = ST_LIST_ENTRY;
                    r.slot           = pick[5:0];
                    r.word_out       = tbl_word[pick];
                    r.count_out      = tbl_count[pick];
                    r.entries_in_use = 7'(n_used);
                    r.last           = (k == lim - 1);
                    pending_results.push_back(r);
                end
            end
        end
    endfunction

    // Either a random bit pattern or a short lowercase word.
    function automatic logic [63:0] random_word();
        logic [63:0] w;
        int          len;
        int          b;
        w = '0;
        if ($urandom_range(1) == 1) begin
            w = {$urandom, $urandom};
        end else begin
            len = $urandom_range(8, 1);
            for (b = 0; b < len; b++) w[8*b +: 8] = 8'(8'h61 + $urandom_range(25));
        end
        return w;
    endfunction

    function automatic in_item_t make_item(logic act, logic [63:0] w);
        in_item_t it;
        it.action       = act;
        it.word         = w;
        it.emotion_code = 4'($urandom);
        it.now_seconds  = $urandom;
        return it;
    endfunction

    // Presents one item, with random idle cycles ahead of it, and predicts it once taken.
    task automatic send_item(in_item_t it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            if (s_valid) s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_item(it);
        items_sent++;
        if (it.action == ACT_LIST) list_items++;
    endtask

    // Holds the input back until every predicted result has arrived.
    task automatic wait_drained();
        if (s_valid) s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // The register is only written with the block idle.
    task automatic write_max_list(logic [4:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        max_list_reg  = value;
        cfg_writes++;
    endtask

    task automatic check_field(string field_name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("field %s: expected 0x%0h, actual 0x%0h", field_name, want, got);
            error_count++;
        end
    endtask

    // A list on an empty table gives a single list-empty item.
    task automatic test_empty_list();
        send_item(make_item(ACT_LIST, random_word()));
        wait_drained();
    endtask

    // Zero and all-ones words, field extremes, a repeat of each and a short list.
    task automatic test_record_extremes();
        in_item_t it;
        it = '{action: ACT_RECORD, word: 64'd0, emotion_code: 4'd0, now_seconds: 32'd0};
        send_item(it);
        it = '{action: ACT_RECORD, word: '1, emotion_code: 4'hF, now_seconds: '1};
        send_item(it);
        send_item(make_item(ACT_RECORD, 64'd0));
        send_item(make_item(ACT_RECORD, '1));
        send_item(make_item(ACT_RECORD, 64'h0000_0000_0074_6163));
        send_item(make_item(ACT_RECORD, '1));
        send_item(make_item(ACT_LIST, 64'd0));
        wait_drained();
    endtask

    // List length at its extremes: zero, one, the maximum and above it.
    task automatic test_list_length();
        logic [4:0]  lengths [5] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd10};
        logic [63:0] w;
        int          n;
        for (n = 0; n < 18; n++) send_item(make_item(ACT_RECORD, random_word()));
        for (n = 0; n < 6; n++) begin
            w = tbl_word[2 + (n % 4)];
            send_item(make_item(ACT_RECORD, w));
        end
        for (n = 0; n < 5; n++) begin
            write_max_list(lengths[n]);
            send_item(make_item(ACT_LIST, random_word()));
        end
        wait_drained();
    endtask

    // Fills every slot, then forces replacements of the least frequent entries.
    task automatic test_table_full();
        while (n_used < TABLE_DEPTH) send_item(make_item(ACT_RECORD, random_word()));
        repeat (4) send_item(make_item(ACT_RECORD, random_word()));
        send_item(make_item(ACT_RECORD, tbl_word[TABLE_DEPTH - 1]));
        send_item(make_item(ACT_LIST, 64'd0));
        wait_drained();
    endtask

    // Mostly words from a recurring pool, some fresh words and some lists.
    task automatic run_random_phase(int sender_pct, int receiver_pct, int n_items);
        int n;
        int roll;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (n = 0; n < n_items; n++) begin
            // The sender sometimes waits for the block to empty completely.
            if (n == n_items / 2 || $urandom_range(99) < 3) wait_drained();
            roll = $urandom_range(99);
            if (roll < 18)
                send_item(make_item(ACT_LIST, random_word()));
            else if (roll < 82)
                send_item(make_item(ACT_RECORD, word_pool[$urandom_range(POOL_SIZE - 1)]));
            else
                send_item(make_item(ACT_RECORD, random_word()));
        end
        wait_drained();
    endtask

    // Compare each result item with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with none predicted: status %0d slot %0d count %0d",
                       m_data.status, m_data.slot, m_data.count_out);
                error_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("status", oldest_result.status, m_data.status);
                check_field("slot", oldest_result.slot, m_data.slot);
                check_field("word_out", oldest_result.word_out, m_data.word_out);
                check_field("count_out", oldest_result.count_out, m_data.count_out);
                check_field("entries_in_use", oldest_result.entries_in_use,
                            m_data.entries_in_use);
                check_field("last", oldest_result.last, m_data.last);
            end
        end
    end

    // Random back-pressure on the result channel.
    always @(posedge aclk) begin
        m_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    // Ends the run if no channel moves an item for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired: %0d cycles without a handshake", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int p;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        n_used        = 0;
        max_list_reg  = 5'd10;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent    = 0;
        list_items    = 0;
        cfg_writes    = 0;
        for (p = 0; p < POOL_SIZE; p++) word_pool[p] = random_word();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_list();
        test_record_extremes();
        test_list_length();
        test_table_full();

        write_max_list(5'($urandom));
        run_random_phase(27, 48, 70);
        write_max_list(5'($urandom));
        run_random_phase(48, 27, 70);
        write_max_list(5'd31);
        run_random_phase(0, 0, 70);

        // Let any stray result surface before the verdict.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d items (%0d lists) and checked %0d results over %0d register writes,",
                 items_sent, list_items, results_seen, cfg_writes);
        $display("covering the empty table, full-table replacement, list limits and stalls.");
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/wftl_pkg.sv
hw/rtl/wftl_datapath.sv
hw/rtl/wftl_ctrl.sv
hw/rtl/word_frequency_table_lfu_top.sv
sim/word_frequency_table_lfu_top_tb.sv
